>>> rtl/gfs_pkg.sv
package gfs_pkg;

  localparam int NUM_CHANNELS = 32;
  localparam int PAIR_COUNT   = NUM_CHANNELS / 2;
  localparam int CH_W         = $clog2(NUM_CHANNELS);
  localparam int PAIR_W       = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam int LEVEL_W      = 12;
  localparam int BYTE_W       = 8;
  localparam int DIV_W        = 8;

  localparam logic [DIV_W-1:0] FRAME_DIV_RESET = 8'd8;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_TICK   = 1'b1;
  localparam logic KIND_LATCH = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVEN,
    S_B0,
    S_B1,
    S_B2
  } state_t;

  typedef enum logic [1:0] {
    SEL_LATCH,
    SEL_B0,
    SEL_B1,
    SEL_B2
  } out_sel_t;

  typedef struct packed {
    logic     wr_en;
    logic     tick_en;
    logic     stream_start;
    logic     rd_en;
    logic     rd_odd;
    logic     rd_next;
    logic     cap_odd;
    logic     cap_even;
    logic     pair_dec;
    logic     emit;
    logic     last;
    out_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic tick_hit;
    logic pair_zero;
  } dp_status_t;

endpackage

>>> rtl/gfs_datapath.sv
module gfs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gfs_pkg::dp_cmd_t              cmd,
  output gfs_pkg::dp_status_t           status,
  input  logic [4:0]                    in_channel,
  input  logic [gfs_pkg::LEVEL_W-1:0]   in_level,
  input  logic                          cfg_wr_en,
  input  logic [gfs_pkg::DIV_W-1:0]     cfg_wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [gfs_pkg::BYTE_W-1:0]    out_data_byte,
  output logic                          out_last
);

  logic [gfs_pkg::LEVEL_W-1:0] level_mem_r [gfs_pkg::NUM_CHANNELS];
  logic [gfs_pkg::NUM_CHANNELS-1:0] valid_r;
  logic [gfs_pkg::LEVEL_W-1:0] rd_data_r;
  logic [gfs_pkg::LEVEL_W-1:0] odd_r;
  logic [gfs_pkg::LEVEL_W-1:0] even_r;
  logic [gfs_pkg::PAIR_W-1:0]  pair_r;
  logic [gfs_pkg::PAIR_W-1:0]  pair_nxt;
  logic [gfs_pkg::PAIR_W-1:0]  rd_pair;
  logic [gfs_pkg::CH_W-1:0]    rd_addr;
  logic [gfs_pkg::CH_W-1:0]    wr_addr;
  logic                        wr_ok;
  logic [gfs_pkg::DIV_W-1:0]   tick_count_r;
  logic [gfs_pkg::DIV_W-1:0]   tick_nxt;
  logic [gfs_pkg::DIV_W-1:0]   frame_div_r;
  logic                        out_valid_r;
  logic                        out_kind_r;
  logic [gfs_pkg::BYTE_W-1:0]  out_byte_r;
  logic                        out_last_r;
  logic                        kind_nxt;
  logic [gfs_pkg::BYTE_W-1:0]  byte_nxt;

  assign wr_addr  = gfs_pkg::CH_W'(in_channel);
  assign wr_ok    = cmd.wr_en && (32'(in_channel) < 32'(gfs_pkg::NUM_CHANNELS));
  assign tick_nxt = tick_count_r + 8'd1;

  always_comb begin
    if (cmd.stream_start) begin
      rd_pair = gfs_pkg::PAIR_W'(gfs_pkg::PAIR_COUNT - 1);
    end else if (cmd.rd_next) begin
      rd_pair = pair_r - 1'b1;
    end else begin
      rd_pair = pair_r;
    end
    rd_addr = gfs_pkg::CH_W'({rd_pair, cmd.rd_odd});
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      level_mem_r[wr_addr] <= in_level;
    end
    if (cmd.rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? level_mem_r[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ok) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_odd) begin
      odd_r <= rd_data_r;
    end
    if (cmd.cap_even) begin
      even_r <= rd_data_r;
    end
  end

  always_comb begin
    pair_nxt = pair_r;
    if (cmd.stream_start) begin
      pair_nxt = gfs_pkg::PAIR_W'(gfs_pkg::PAIR_COUNT - 1);
    end else if (cmd.pair_dec) begin
      pair_nxt = pair_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r       <= '0;
      tick_count_r <= '0;
      frame_div_r  <= gfs_pkg::FRAME_DIV_RESET;
    end else begin
      pair_r <= pair_nxt;
      if (cmd.tick_en) begin
        tick_count_r <= cmd.stream_start ? '0 : tick_nxt;
      end
      if (cfg_wr_en) begin
        frame_div_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    kind_nxt = gfs_pkg::KIND_DATA;
    case (cmd.sel)
      gfs_pkg::SEL_LATCH: begin
        kind_nxt = gfs_pkg::KIND_LATCH;
        byte_nxt = '0;
      end
      gfs_pkg::SEL_B0: byte_nxt = odd_r[11:4];
      gfs_pkg::SEL_B1: byte_nxt = {odd_r[3:0], even_r[11:8]};
      gfs_pkg::SEL_B2: byte_nxt = even_r[7:0];
      default:         byte_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= kind_nxt;
      out_byte_r <= byte_nxt;
      out_last_r <= cmd.last;
    end
  end

  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.tick_hit  = (tick_nxt == frame_div_r);
  assign status.pair_zero = (pair_r == '0);

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data_byte = out_byte_r;
  assign out_last      = out_last_r;

endmodule

>>> rtl/gfs_ctrl.sv
module gfs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_stall,
  input  gfs_pkg::dp_status_t  status,
  output gfs_pkg::dp_cmd_t     cmd
);

  gfs_pkg::state_t state_r;
  gfs_pkg::state_t state_nxt;
  logic            accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = gfs_pkg::SEL_LATCH;
    in_stall  = (state_r != gfs_pkg::S_IDLE) ||
                (in_command == gfs_pkg::CMD_TICK && !status.out_free);
    accept    = in_valid && !in_stall;
    case (state_r)
      gfs_pkg::S_IDLE: begin
        if (accept && in_command == gfs_pkg::CMD_WRITE) begin
          cmd.wr_en = 1'b1;
        end else if (accept) begin
          cmd.tick_en = 1'b1;
          cmd.emit    = 1'b1;
          cmd.sel     = gfs_pkg::SEL_LATCH;
          if (status.tick_hit) begin
            cmd.stream_start = 1'b1;
            cmd.rd_en        = 1'b1;
            cmd.rd_odd       = 1'b1;
            state_nxt        = gfs_pkg::S_EVEN;
          end else begin
            cmd.last = 1'b1;
          end
        end
      end
      gfs_pkg::S_EVEN: begin
        cmd.rd_en   = 1'b1;
        cmd.cap_odd = 1'b1;
        state_nxt   = gfs_pkg::S_B0;
      end
      gfs_pkg::S_B0: begin
        cmd.cap_even = 1'b1;
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = gfs_pkg::SEL_B0;
          state_nxt = gfs_pkg::S_B1;
        end
      end
      gfs_pkg::S_B1: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = gfs_pkg::SEL_B1;
          state_nxt = gfs_pkg::S_B2;
          if (!status.pair_zero) begin
            cmd.rd_en   = 1'b1;
            cmd.rd_odd  = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      gfs_pkg::S_B2: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = gfs_pkg::SEL_B2;
          cmd.last = status.pair_zero;
          if (status.pair_zero) begin
            state_nxt = gfs_pkg::S_IDLE;
          end else begin
            cmd.rd_en    = 1'b1;
            cmd.rd_next  = 1'b1;
            cmd.cap_odd  = 1'b1;
            cmd.pair_dec = 1'b1;
            state_nxt    = gfs_pkg::S_B0;
          end
        end
      end
      default: state_nxt = gfs_pkg::S_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result loaded while output register busy");

  a_start_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stream_start |-> (status.tick_hit && cmd.emit && !cmd.last))
    else $error("frame stream started without divider hit");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gfs_pkg::S_B2 && cmd.emit && status.pair_zero) |=>
    (state_r == gfs_pkg::S_IDLE))
    else $error("controller did not return to idle after final byte");

  a_wr_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (!cmd.rd_en && !cmd.emit))
    else $error("level write overlaps a frame read");

endmodule

>>> rtl/grayscale_frame_serializer_unit.sv
// A tick item's latch pulse is presented in the cycle after the item is accepted.
// Throughput: a frame tick stalls the input until its frame is sent; the frame's data bytes
//   follow at one byte per cycle while out_stall is low, three per channel pair (48 at 32
//   channels), from a level memory read one channel at a time.
// Reset (synchronous, rst_n low): all levels read as zero, divider count zero,
//   frame_divider back to 8, output empty.
module grayscale_frame_serializer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [4:0]                   in_channel,
  input  logic [gfs_pkg::LEVEL_W-1:0]  in_level,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_kind,
  output logic [gfs_pkg::BYTE_W-1:0]   out_data_byte,
  output logic                         out_last,
  input  logic                         cfg_wr_en,
  input  logic [gfs_pkg::DIV_W-1:0]    cfg_wr_data
);

  gfs_pkg::dp_cmd_t    cmd;
  gfs_pkg::dp_status_t status;

  gfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  gfs_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_channel    (in_channel),
    .in_level      (in_level),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

endmodule
